// ===== rtl/adsr_pkg.sv =====
package adsr_pkg;

	localparam int LEVEL_FRAC_BITS_DEF = 24;
	localparam int PULSE_COUNT_BITS_DEF = 10;
	localparam int SAMPLE_W = 24;
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	// gate and trigger threshold, one half in Q1.23
	localparam logic signed [SAMPLE_W-1:0] HALF_Q23 = 24'sh400000;

	// register indexes (byte address / 4)
	localparam logic [2:0] REG_ATTACK_STEP = 3'd0;
	localparam logic [2:0] REG_DECAY_COEFF = 3'd1;
	localparam logic [2:0] REG_SUSTAIN_LEVEL = 3'd2;
	localparam logic [2:0] REG_RELEASE_COEFF = 3'd3;
	localparam logic [2:0] REG_PULSE_LENGTH = 3'd4;

	localparam int ATTACK_STEP_RST = 38043;
	localparam int DECAY_COEFF_RST = 3804;
	localparam int SUSTAIN_LEVEL_RST = 11744051;
	localparam int RELEASE_COEFF_RST = 1902;
	localparam int PULSE_LENGTH_RST = 44;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_ATTACK = 3'd1,
		PH_DECAY = 3'd2,
		PH_SUSTAIN = 3'd3,
		PH_RELEASE = 3'd4
	} adsr_phase_t;

	typedef struct packed {
		logic went_idle;
		logic at_sustain;
	} adsr_pulse_evt_t;

endpackage

// ===== rtl/adsr_envelope_generator.sv =====
// a sample transfer is registered in stage 1, then in the result register
// throughput: one sample per cycle if not stalled; level update is one multiply and compare
// a result waiting in the output register holds the input back once the input register is full
// reset: asynchronous, active low; phase idle, level zero, pulse counters zero,
// registers at their default values
module adsr_envelope_generator #(
	parameter int LEVEL_FRAC_BITS = adsr_pkg::LEVEL_FRAC_BITS_DEF,
	parameter int PULSE_COUNT_BITS = adsr_pkg::PULSE_COUNT_BITS_DEF,
	localparam int LW = LEVEL_FRAC_BITS + 1
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [adsr_pkg::PADDR_W-1:0]          paddr,
	input  logic [adsr_pkg::PDATA_W-1:0]          pwdata,
	output logic [adsr_pkg::PDATA_W-1:0]          prdata,
	output logic                                  pready,
	input  logic                                  sample_valid,
	output logic                                  sample_ready,
	input  logic signed [adsr_pkg::SAMPLE_W-1:0]  gate_sample,
	input  logic signed [adsr_pkg::SAMPLE_W-1:0]  trigger_sample,
	output logic                                  result_valid,
	input  logic                                  result_ready,
	output logic [LW-1:0]                         envelope,
	output logic [LW-1:0]                         inverted_envelope,
	output logic                                  end_of_release_gate,
	output logic                                  end_of_cycle_gate,
	output logic [2:0]                            phase
);

	localparam logic [LW-1:0] ONE = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};

	logic [LW-1:0]                        attack_step;
	logic [LW-1:0]                        decay_coeff;
	logic [LW-1:0]                        sustain_level;
	logic [LW-1:0]                        release_coeff;
	logic [PULSE_COUNT_BITS-1:0]          pulse_length;
	logic                                 valid_s1;
	logic signed [adsr_pkg::SAMPLE_W-1:0] gate_s1;
	logic signed [adsr_pkg::SAMPLE_W-1:0] trig_s1;
	logic                                 advance;
	logic [LW-1:0]                        level_nx;
	adsr_pkg::adsr_phase_t                phase_nx;
	adsr_pkg::adsr_pulse_evt_t            evt;
	logic                                 eor;
	logic                                 eoc;
	logic                                 result_valid_q;
	logic [LW-1:0]                        envelope_q;
	logic [LW-1:0]                        inverted_q;
	logic                                 eor_q;
	logic                                 eoc_q;
	logic [2:0]                           phase_q;

	assign pready = 1'b1;

	adsr_cfg #(
		.LEVEL_FRAC_BITS(LEVEL_FRAC_BITS),
		.PULSE_COUNT_BITS(PULSE_COUNT_BITS)
	) u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.attack_step(attack_step),
		.decay_coeff(decay_coeff),
		.sustain_level(sustain_level),
		.release_coeff(release_coeff),
		.pulse_length(pulse_length)
	);

	// stage 1 moves into the result register when that is free or being drained
	assign advance = valid_s1 && (!result_valid_q || result_ready);
	assign sample_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (sample_ready)
			valid_s1 <= sample_valid;
	end

	always_ff @(posedge clk) begin
		if (sample_ready && sample_valid) begin
			gate_s1 <= gate_sample;
			trig_s1 <= trigger_sample;
		end
	end

	adsr_env #(
		.LEVEL_FRAC_BITS(LEVEL_FRAC_BITS)
	) u_env (
		.clk(clk),
		.arst_n(arst_n),
		.advance(advance),
		.gate_sample(gate_s1),
		.trigger_sample(trig_s1),
		.attack_step(attack_step),
		.decay_coeff(decay_coeff),
		.sustain_level(sustain_level),
		.release_coeff(release_coeff),
		.level_nx(level_nx),
		.phase_nx(phase_nx),
		.evt(evt)
	);

	adsr_pulse #(
		.PULSE_COUNT_BITS(PULSE_COUNT_BITS)
	) u_pulse (
		.clk(clk),
		.arst_n(arst_n),
		.advance(advance),
		.evt(evt),
		.pulse_length(pulse_length),
		.eor(eor),
		.eoc(eoc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid_q <= 1'b0;
		else if (advance)
			result_valid_q <= 1'b1;
		else if (result_ready)
			result_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			envelope_q <= level_nx;
			inverted_q <= ONE - level_nx;
			eor_q <= eor;
			eoc_q <= eoc;
			phase_q <= phase_nx;
		end
	end

	assign result_valid = result_valid_q;
	assign envelope = envelope_q;
	assign inverted_envelope = inverted_q;
	assign end_of_release_gate = eor_q;
	assign end_of_cycle_gate = eoc_q;
	assign phase = phase_q;

endmodule

// ===== rtl/adsr_cfg.sv =====
module adsr_cfg #(
	parameter int LEVEL_FRAC_BITS = adsr_pkg::LEVEL_FRAC_BITS_DEF,
	parameter int PULSE_COUNT_BITS = adsr_pkg::PULSE_COUNT_BITS_DEF,
	localparam int LW = LEVEL_FRAC_BITS + 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [adsr_pkg::PADDR_W-1:0]  paddr,
	input  logic [adsr_pkg::PDATA_W-1:0]  pwdata,
	output logic [adsr_pkg::PDATA_W-1:0]  prdata,
	output logic [LW-1:0]                 attack_step,
	output logic [LW-1:0]                 decay_coeff,
	output logic [LW-1:0]                 sustain_level,
	output logic [LW-1:0]                 release_coeff,
	output logic [PULSE_COUNT_BITS-1:0]   pulse_length
);

	logic [2:0] reg_idx;
	logic       wr_en;

	assign reg_idx = paddr[adsr_pkg::PADDR_W-1:2];
	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_step <= LW'(adsr_pkg::ATTACK_STEP_RST);
			decay_coeff <= LW'(adsr_pkg::DECAY_COEFF_RST);
			sustain_level <= LW'(adsr_pkg::SUSTAIN_LEVEL_RST);
			release_coeff <= LW'(adsr_pkg::RELEASE_COEFF_RST);
			pulse_length <= PULSE_COUNT_BITS'(adsr_pkg::PULSE_LENGTH_RST);
		end else if (wr_en) begin
			unique case (reg_idx)
				adsr_pkg::REG_ATTACK_STEP: attack_step <= pwdata[LW-1:0];
				adsr_pkg::REG_DECAY_COEFF: decay_coeff <= pwdata[LW-1:0];
				adsr_pkg::REG_SUSTAIN_LEVEL: sustain_level <= pwdata[LW-1:0];
				adsr_pkg::REG_RELEASE_COEFF: release_coeff <= pwdata[LW-1:0];
				adsr_pkg::REG_PULSE_LENGTH: pulse_length <= pwdata[PULSE_COUNT_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			adsr_pkg::REG_ATTACK_STEP: prdata = adsr_pkg::PDATA_W'(attack_step);
			adsr_pkg::REG_DECAY_COEFF: prdata = adsr_pkg::PDATA_W'(decay_coeff);
			adsr_pkg::REG_SUSTAIN_LEVEL: prdata = adsr_pkg::PDATA_W'(sustain_level);
			adsr_pkg::REG_RELEASE_COEFF: prdata = adsr_pkg::PDATA_W'(release_coeff);
			adsr_pkg::REG_PULSE_LENGTH: prdata = adsr_pkg::PDATA_W'(pulse_length);
			default: prdata = '0;
		endcase
	end

endmodule

// ===== rtl/adsr_env.sv =====
module adsr_env #(
	parameter int LEVEL_FRAC_BITS = adsr_pkg::LEVEL_FRAC_BITS_DEF,
	localparam int LW = LEVEL_FRAC_BITS + 1
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  advance,
	input  logic signed [adsr_pkg::SAMPLE_W-1:0]  gate_sample,
	input  logic signed [adsr_pkg::SAMPLE_W-1:0]  trigger_sample,
	input  logic [LW-1:0]                         attack_step,
	input  logic [LW-1:0]                         decay_coeff,
	input  logic [LW-1:0]                         sustain_level,
	input  logic [LW-1:0]                         release_coeff,
	output logic [LW-1:0]                         level_nx,
	output adsr_pkg::adsr_phase_t                 phase_nx,
	output adsr_pkg::adsr_pulse_evt_t             evt
);

	localparam logic [LW-1:0] ONE = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};
	localparam longint EPS_L = ((longint'(1) << LEVEL_FRAC_BITS) * 5 + 5000) / 10000;
	localparam logic [LW-1:0] EPS = LW'(EPS_L);

	function automatic logic [LW-1:0] coeff_of(input logic [LW-1:0] v);
		logic [LW-1:0] r;
		if (v > ONE)
			r = ONE;
		else if (v == '0)
			r = LW'(1);
		else
			r = v;
		return r;
	endfunction

	adsr_pkg::adsr_phase_t phase_q;
	adsr_pkg::adsr_phase_t ph0;
	logic [LW-1:0]   level_q;
	logic            prev_gate_q;
	logic            prev_trig_q;
	logic            gate_hi;
	logic            trig_hi;
	logic            was_active;
	logic [LW-1:0]   sus;
	logic            dec_up;
	logic [LW-1:0]   dec_dist;
	logic [LW-1:0]   mul_a;
	logic [LW-1:0]   mul_c;
	logic [2*LW-1:0] prod;
	logic [2*LW-1:0] prod_rnd;
	logic [LW-1:0]   step;
	logic [LW:0]     att_sum;
	logic [LW-1:0]   rel_lvl;

	assign gate_hi = gate_sample > adsr_pkg::HALF_Q23;
	assign trig_hi = trigger_sample > adsr_pkg::HALF_Q23;
	assign sus = (sustain_level > ONE) ? ONE : sustain_level;

	always_comb begin
		// edges on gate and trigger override the running phase
		priority if (trig_hi && !prev_trig_q)
			ph0 = adsr_pkg::PH_ATTACK;
		else if (gate_hi && !prev_gate_q)
			ph0 = adsr_pkg::PH_ATTACK;
		else if (!gate_hi && prev_gate_q && phase_q != adsr_pkg::PH_IDLE)
			ph0 = adsr_pkg::PH_RELEASE;
		else
			ph0 = phase_q;
	end

	assign was_active = ph0 != adsr_pkg::PH_IDLE;
	assign dec_up = sus >= level_q;
	assign dec_dist = dec_up ? sus - level_q : level_q - sus;

	// one multiplier shared by decay and release
	assign mul_a = (ph0 == adsr_pkg::PH_DECAY) ? dec_dist : level_q;
	assign mul_c = (ph0 == adsr_pkg::PH_DECAY) ? coeff_of(decay_coeff) : coeff_of(release_coeff);
	assign prod = (2*LW)'(mul_a) * (2*LW)'(mul_c);
	assign prod_rnd = prod + (2*LW)'(ONE - LW'(1));
	assign step = prod_rnd[LEVEL_FRAC_BITS +: LW];

	assign att_sum = {1'b0, level_q} + {1'b0, coeff_of(attack_step)};
	assign rel_lvl = level_q - step;

	always_comb begin
		unique case (ph0)
			adsr_pkg::PH_ATTACK: begin
				if (att_sum >= {1'b0, ONE}) begin
					level_nx = ONE;
					phase_nx = adsr_pkg::PH_DECAY;
				end else begin
					level_nx = att_sum[LW-1:0];
					phase_nx = adsr_pkg::PH_ATTACK;
				end
			end
			adsr_pkg::PH_DECAY: begin
				// step never exceeds the distance, so the new distance is a subtract
				if ((dec_dist - step) < EPS) begin
					level_nx = sus;
					phase_nx = adsr_pkg::PH_SUSTAIN;
				end else begin
					level_nx = dec_up ? level_q + step : level_q - step;
					phase_nx = adsr_pkg::PH_DECAY;
				end
			end
			adsr_pkg::PH_SUSTAIN: begin
				level_nx = sus;
				phase_nx = gate_hi ? adsr_pkg::PH_SUSTAIN : adsr_pkg::PH_RELEASE;
			end
			adsr_pkg::PH_RELEASE: begin
				if (rel_lvl <= EPS) begin
					level_nx = '0;
					phase_nx = adsr_pkg::PH_IDLE;
				end else begin
					level_nx = rel_lvl;
					phase_nx = adsr_pkg::PH_RELEASE;
				end
			end
			default: begin
				level_nx = '0;
				phase_nx = adsr_pkg::PH_IDLE;
			end
		endcase
	end

	assign evt.went_idle = was_active && (phase_nx == adsr_pkg::PH_IDLE);
	assign evt.at_sustain = phase_nx == adsr_pkg::PH_SUSTAIN;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= adsr_pkg::PH_IDLE;
			level_q <= '0;
			prev_gate_q <= 1'b0;
			prev_trig_q <= 1'b0;
		end else if (advance) begin
			phase_q <= phase_nx;
			level_q <= level_nx;
			prev_gate_q <= gate_hi;
			prev_trig_q <= trig_hi;
		end
	end

endmodule

// ===== rtl/adsr_pulse.sv =====
module adsr_pulse #(
	parameter int PULSE_COUNT_BITS = adsr_pkg::PULSE_COUNT_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        advance,
	input  adsr_pkg::adsr_pulse_evt_t   evt,
	input  logic [PULSE_COUNT_BITS-1:0] pulse_length,
	output logic                        eor,
	output logic                        eoc
);

	logic [PULSE_COUNT_BITS-1:0] rel_cnt_q;
	logic [PULSE_COUNT_BITS-1:0] cyc_cnt_q;
	logic                        prev_at_sus_q;
	logic [PULSE_COUNT_BITS-1:0] rel_ld;
	logic [PULSE_COUNT_BITS-1:0] cyc_ld;

	always_comb begin
		rel_ld = evt.went_idle ? pulse_length : rel_cnt_q;
		cyc_ld = evt.went_idle ? pulse_length : cyc_cnt_q;
		if (evt.at_sustain && !prev_at_sus_q)
			cyc_ld = pulse_length;
	end

	// gate shows the count before this sample's decrement
	assign eor = rel_ld != '0;
	assign eoc = cyc_ld != '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rel_cnt_q <= '0;
			cyc_cnt_q <= '0;
			prev_at_sus_q <= 1'b0;
		end else if (advance) begin
			rel_cnt_q <= eor ? rel_ld - PULSE_COUNT_BITS'(1) : rel_ld;
			cyc_cnt_q <= eoc ? cyc_ld - PULSE_COUNT_BITS'(1) : cyc_ld;
			prev_at_sus_q <= evt.at_sustain;
		end
	end

endmodule

// ===== rtl/adsr_checker.sv =====
module adsr_checker #(
	parameter int LEVEL_FRAC_BITS = adsr_pkg::LEVEL_FRAC_BITS_DEF,
	localparam int LW = LEVEL_FRAC_BITS + 1
) (
	input logic          clk,
	input logic          arst_n,
	input logic          result_valid,
	input logic          result_ready,
	input logic [LW-1:0] envelope,
	input logic [LW-1:0] inverted_envelope,
	input logic [2:0]    phase
);

	localparam logic [LW:0] ONE_X = {2'b01, {LEVEL_FRAC_BITS{1'b0}}};

	// a stalled result keeps its level
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(envelope))
		else $error("result changed while stalled");

	a_sum: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ({1'b0, envelope} + {1'b0, inverted_envelope}) == ONE_X)
		else $error("envelope and inverse do not add to full scale");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> {1'b0, envelope} <= ONE_X)
		else $error("envelope above full scale");

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (phase == adsr_pkg::PH_IDLE) |-> envelope == '0)
		else $error("idle with nonzero level");

endmodule

bind adsr_envelope_generator adsr_checker #(
	.LEVEL_FRAC_BITS(LEVEL_FRAC_BITS)
) u_adsr_checker (
	.clk(clk),
	.arst_n(arst_n),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.envelope(envelope),
	.inverted_envelope(inverted_envelope),
	.phase(phase)
);

// ===== tb/sv/adsr_envelope_generator_test.sv =====
module adsr_envelope_generator_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LFB = adsr_pkg::LEVEL_FRAC_BITS_DEF;
	localparam int LW = LFB + 1;
	localparam int PCB = adsr_pkg::PULSE_COUNT_BITS_DEF;
	localparam longint unsigned FULL = 64'd1 << LFB;
	// snap distance, 0.0005 of full scale rounded to nearest
	localparam longint unsigned SNAP_DIST = (FULL * 5 + 5000) / 10000;
	localparam logic signed [adsr_pkg::SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;
	localparam logic signed [adsr_pkg::SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
	localparam logic [adsr_pkg::PDATA_W-1:0] WORD_ONES = '1;

	typedef struct packed {
		logic [LW-1:0] envelope;
		logic [LW-1:0] inverted;
		logic end_of_release;
		logic end_of_cycle;
		logic [2:0] phase;
	} envelope_t;

	class envelope_scoreboard;
		bit [LW-1:0] attack_step, decay_coeff, sustain_level, release_coeff;
		bit [PCB-1:0] pulse_length;
		adsr_pkg::adsr_phase_t cur_phase;
		bit [LW-1:0] level;
		bit last_gate, last_trigger, last_at_sustain;
		bit [PCB-1:0] release_count, cycle_count;
		envelope_t envelopes_due[$];
		int unsigned mismatches;

		function new();
			attack_step = LW'(adsr_pkg::ATTACK_STEP_RST);
			decay_coeff = LW'(adsr_pkg::DECAY_COEFF_RST);
			sustain_level = LW'(adsr_pkg::SUSTAIN_LEVEL_RST);
			release_coeff = LW'(adsr_pkg::RELEASE_COEFF_RST);
			pulse_length = PCB'(adsr_pkg::PULSE_LENGTH_RST);
			cur_phase = adsr_pkg::PH_IDLE;
			level = '0;
			mismatches = 0;
		endfunction

		function void set_register(logic [2:0] idx, logic [adsr_pkg::PDATA_W-1:0] value);
			unique case (idx)
				adsr_pkg::REG_ATTACK_STEP: attack_step = value[LW-1:0];
				adsr_pkg::REG_DECAY_COEFF: decay_coeff = value[LW-1:0];
				adsr_pkg::REG_SUSTAIN_LEVEL: sustain_level = value[LW-1:0];
				adsr_pkg::REG_RELEASE_COEFF: release_coeff = value[LW-1:0];
				adsr_pkg::REG_PULSE_LENGTH: pulse_length = value[PCB-1:0];
				default: ;
			endcase
		endfunction

		function longint unsigned clamp_full(longint unsigned v);
			return v > FULL ? FULL : v;
		endfunction

		// zero rates behave as the smallest nonzero rate
		function longint unsigned rate_of(longint unsigned v);
			v = clamp_full(v);
			return v == 0 ? 1 : v;
		endfunction

		// ceil(gap * coeff / full scale)
		function longint unsigned part_of(longint unsigned gap, longint unsigned coeff);
			return (gap * coeff + FULL - 1) >> LFB;
		endfunction

		function int pending();
			return envelopes_due.size();
		endfunction

		function void take_sample(logic signed [adsr_pkg::SAMPLE_W-1:0] gate_s,
				logic signed [adsr_pkg::SAMPLE_W-1:0] trig_s);
			bit gate_hi, trig_hi, was_active, at_sus;
			longint unsigned sus, nxt, gap;
			envelope_t r;
			gate_hi = gate_s > adsr_pkg::HALF_Q23;
			trig_hi = trig_s > adsr_pkg::HALF_Q23;
			sus = clamp_full(sustain_level);
			if (trig_hi && !last_trigger)
				cur_phase = adsr_pkg::PH_ATTACK;
			else if (gate_hi && !last_gate)
				cur_phase = adsr_pkg::PH_ATTACK;
			else if (!gate_hi && last_gate && cur_phase != adsr_pkg::PH_IDLE)
				cur_phase = adsr_pkg::PH_RELEASE;
			last_trigger = trig_hi;
			last_gate = gate_hi;
			was_active = cur_phase != adsr_pkg::PH_IDLE;

			case (cur_phase)
				adsr_pkg::PH_ATTACK: begin
					nxt = level + rate_of(attack_step);
					if (nxt >= FULL) begin
						nxt = FULL;
						cur_phase = adsr_pkg::PH_DECAY;
					end
					level = nxt[LW-1:0];
				end
				adsr_pkg::PH_DECAY: begin
					if (sus >= level)
						nxt = level + part_of(sus - level, rate_of(decay_coeff));
					else
						nxt = level - part_of(level - sus, rate_of(decay_coeff));
					gap = nxt >= sus ? nxt - sus : sus - nxt;
					if (gap < SNAP_DIST) begin
						nxt = sus;
						cur_phase = adsr_pkg::PH_SUSTAIN;
					end
					level = nxt[LW-1:0];
				end
				adsr_pkg::PH_SUSTAIN: begin
					level = sus[LW-1:0];
					if (!gate_hi)
						cur_phase = adsr_pkg::PH_RELEASE;
				end
				adsr_pkg::PH_RELEASE: begin
					nxt = level - part_of(level, rate_of(release_coeff));
					if (nxt <= SNAP_DIST) begin
						nxt = 0;
						cur_phase = adsr_pkg::PH_IDLE;
					end
					level = nxt[LW-1:0];
				end
				default: begin
					cur_phase = adsr_pkg::PH_IDLE;
					level = '0;
				end
			endcase

			if (was_active && cur_phase == adsr_pkg::PH_IDLE) begin
				release_count = pulse_length;
				cycle_count = pulse_length;
			end
			at_sus = cur_phase == adsr_pkg::PH_SUSTAIN;
			if (at_sus && !last_at_sustain)
				cycle_count = pulse_length;
			last_at_sustain = at_sus;

			r.end_of_release = release_count != 0;
			r.end_of_cycle = cycle_count != 0;
			if (release_count != 0)
				release_count--;
			if (cycle_count != 0)
				cycle_count--;
			r.envelope = level;
			r.inverted = LW'(FULL - level);
			r.phase = cur_phase;
			envelopes_due = {envelopes_due, r};
		endfunction

		function void check_envelope(envelope_t got);
			envelope_t want;
			if (envelopes_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: env=%0d inv=%0d eor=%0b eoc=%0b phase=%0d",
						got.envelope, got.inverted, got.end_of_release,
						got.end_of_cycle, got.phase);
				return;
			end
			want = envelopes_due.pop_front();
			if (got.envelope !== want.envelope || got.inverted !== want.inverted ||
					got.end_of_release !== want.end_of_release ||
					got.end_of_cycle !== want.end_of_cycle || got.phase !== want.phase) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch: expected env=%0d inv=%0d eor=%0b eoc=%0b phase=%0d",
						want.envelope, want.inverted, want.end_of_release,
						want.end_of_cycle, want.phase);
					$display("          actual   env=%0d inv=%0d eor=%0b eoc=%0b phase=%0d",
						got.envelope, got.inverted, got.end_of_release,
						got.end_of_cycle, got.phase);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [adsr_pkg::PADDR_W-1:0] paddr = '0;
	logic [adsr_pkg::PDATA_W-1:0] pwdata = '0;
	logic [adsr_pkg::PDATA_W-1:0] prdata;
	logic pready;
	logic sample_valid = 1'b0;
	logic sample_ready;
	logic signed [adsr_pkg::SAMPLE_W-1:0] gate_sample = '0;
	logic signed [adsr_pkg::SAMPLE_W-1:0] trigger_sample = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	logic [LW-1:0] envelope;
	logic [LW-1:0] inverted_envelope;
	logic end_of_release_gate;
	logic end_of_cycle_gate;
	logic [2:0] phase;

	int send_idle_pct = 11;
	int recv_idle_pct = 57;
	envelope_scoreboard sb;

	adsr_envelope_generator dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.gate_sample(gate_sample),
		.trigger_sample(trigger_sample),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.envelope(envelope),
		.inverted_envelope(inverted_envelope),
		.end_of_release_gate(end_of_release_gate),
		.end_of_cycle_gate(end_of_cycle_gate),
		.phase(phase)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			sb.check_envelope({envelope, inverted_envelope, end_of_release_gate,
				end_of_cycle_gate, phase});
		result_ready <= $urandom_range(99) >= recv_idle_pct;
	end

	task automatic send_sample(input logic signed [adsr_pkg::SAMPLE_W-1:0] g,
			input logic signed [adsr_pkg::SAMPLE_W-1:0] t);
		while ($urandom_range(99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		gate_sample <= g;
		trigger_sample <= t;
		do @(posedge clk); while (!sample_ready);
		sb.take_sample(g, t);
	endtask

	// drop valid after the last transfer and let the block empty out
	task automatic settle();
		sample_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(input logic [2:0] idx,
			input logic [adsr_pkg::PDATA_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_register(idx, value);
	endtask

	task automatic write_config(input logic [adsr_pkg::PDATA_W-1:0] atk,
			input logic [adsr_pkg::PDATA_W-1:0] dcy,
			input logic [adsr_pkg::PDATA_W-1:0] sus, input logic [adsr_pkg::PDATA_W-1:0] rel,
			input logic [adsr_pkg::PDATA_W-1:0] plen);
		write_register(adsr_pkg::REG_ATTACK_STEP, atk);
		write_register(adsr_pkg::REG_DECAY_COEFF, dcy);
		write_register(adsr_pkg::REG_SUSTAIN_LEVEL, sus);
		write_register(adsr_pkg::REG_RELEASE_COEFF, rel);
		write_register(adsr_pkg::REG_PULSE_LENGTH, plen);
	endtask

	// mostly fast rates so that notes run through every phase
	function automatic logic [adsr_pkg::PDATA_W-1:0] pick_rate(input int slowest_div);
		unique case ($urandom_range(9))
			0: return '0;
			1: return $urandom_range(32'h1FF_FFFF, 32'(FULL) + 1);
			2: return 32'(FULL);
			default: return $urandom_range(32'(FULL), 32'(FULL) / slowest_div);
		endcase
	endfunction

	function automatic logic [adsr_pkg::PDATA_W-1:0] pick_sustain();
		unique case ($urandom_range(9))
			0: return '0;
			1: return $urandom_range(32'h1FF_FFFF, 32'(FULL) + 1);
			2: return 32'(FULL);
			default: return $urandom_range(32'(FULL), 0);
		endcase
	endfunction

	function automatic logic [adsr_pkg::PDATA_W-1:0] pick_pulse();
		unique case ($urandom_range(9))
			0: return '0;
			1: return (1 << PCB) - 1;
			default: return $urandom_range(40, 1);
		endcase
	endfunction

	function automatic logic signed [adsr_pkg::SAMPLE_W-1:0] sample_of(input bit hi);
		if (hi) begin
			if ($urandom_range(19) == 0)
				return adsr_pkg::SAMPLE_W'(adsr_pkg::HALF_Q23 + 1);
			return adsr_pkg::SAMPLE_W'($urandom_range(24'h7FFFFF, 24'h400001));
		end
		unique case ($urandom_range(19))
			0: return adsr_pkg::HALF_Q23;
			1, 2, 3, 4, 5, 6, 7, 8: return {1'b1, 23'($urandom)};
			default: return adsr_pkg::SAMPLE_W'($urandom_range(24'h400000, 0));
		endcase
	endfunction

	task automatic play_notes(input int quota);
		int sent, kind, on_len, off_len, retrig_at;
		bit by_trigger, g, t;
		sent = 0;
		while (sent < quota) begin
			kind = $urandom_range(99);
			if (kind < 20) begin
				repeat ($urandom_range(6, 1)) begin
					send_sample(adsr_pkg::SAMPLE_W'($urandom),
						adsr_pkg::SAMPLE_W'($urandom));
					sent++;
				end
			end else begin
				by_trigger = kind < 35;
				on_len = $urandom_range(80, 1);
				off_len = $urandom_range(60, 1);
				retrig_at = $urandom_range(on_len * 2, 0);
				for (int i = 0; i < on_len + off_len; i++) begin
					g = !by_trigger && i < on_len;
					t = by_trigger ? i < 2 : (i == retrig_at || i == retrig_at + 1);
					send_sample(sample_of(g), sample_of(t));
					sent++;
				end
			end
		end
	endtask

	task automatic run_directed();
		// reset settings: field extremes, exact threshold, both kinds of rise
		send_sample(SAMPLE_MIN, SAMPLE_MIN);
		send_sample(adsr_pkg::HALF_Q23, adsr_pkg::HALF_Q23);
		send_sample(adsr_pkg::SAMPLE_W'(adsr_pkg::HALF_Q23 + 1), '0);
		send_sample(SAMPLE_MAX, SAMPLE_MAX);
		send_sample(SAMPLE_MAX, '0);
		// gate fall together with trigger rise: the trigger wins
		send_sample('0, SAMPLE_MAX);
		send_sample('0, '0);
		send_sample(SAMPLE_MAX, '0);
		send_sample(SAMPLE_MIN, '0);
		send_sample(SAMPLE_MIN, '0);
		settle();

		// one-sample phases to walk the whole cycle quickly
		write_config(32'(FULL), 32'(FULL), 32'(FULL / 2), 32'(FULL), 2);
		send_sample(SAMPLE_MAX, '0);
		send_sample(SAMPLE_MAX, '0);
		send_sample(SAMPLE_MAX, '0);
		send_sample(SAMPLE_MAX, '0);
		send_sample(SAMPLE_MIN, '0);
		repeat (3) send_sample(SAMPLE_MIN, '0);
		// trigger alone: sustain with gate low drops into release
		send_sample(SAMPLE_MIN, SAMPLE_MAX);
		send_sample(SAMPLE_MIN, SAMPLE_MAX);
		send_sample(SAMPLE_MIN, '0);
		send_sample(SAMPLE_MIN, '0);
	endtask

	initial begin
		#3_000_000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();

		for (int p = 0; p < 9; p++) begin
			settle();
			if (p < 3) begin
				send_idle_pct = 11;
				recv_idle_pct = 57;
			end else if (p < 6) begin
				send_idle_pct = 57;
				recv_idle_pct = 11;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			case (p)
				0: begin
					// all ones: bits above the register are dropped, values saturate
					write_config(WORD_ONES, WORD_ONES, WORD_ONES, WORD_ONES, WORD_ONES);
					for (int i = adsr_pkg::REG_PULSE_LENGTH + 1; i < 8; i++)
						write_register(3'(i), '0);
				end
				4: write_config('0, '0, '0, '0, '0);
				7: write_config(32'(FULL), 32'(FULL), 32'(FULL / 2), 32'(FULL), 1);
				default: write_config(pick_rate(32), pick_rate(8), pick_sustain(),
					pick_rate(8), pick_pulse());
			endcase
			play_notes(p == 4 ? 40 : 105);
		end
		settle();

		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
